@@ rtl/debug_breakpoint_table_unit_assert.svh @@
// Assertion macros for the breakpoint table unit.
`ifndef DEBUG_BREAKPOINT_TABLE_UNIT_ASSERT_SVH
`define DEBUG_BREAKPOINT_TABLE_UNIT_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define DBT_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("breakpoint table: same-cycle check failed");

// Consequent checked in the cycle after the antecedent.
`define DBT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("breakpoint table: next-cycle check failed");

`endif

@@ rtl/dbt_pkg.sv @@
package dbt_pkg;

   localparam int ENTRIES_DEFAULT = 8;

   localparam logic [1:0] OP_CHECK  = 2'd0;
   localparam logic [1:0] OP_TOGGLE = 2'd1;
   localparam logic [1:0] OP_WRITE  = 2'd2;
   localparam logic [1:0] OP_NOP    = 2'd3;

   localparam logic [2:0] KIND_NONE = 3'd0;
   localparam logic [2:0] KIND_EXEC = 3'd1;
   localparam logic [2:0] KIND_WMEM = 3'd2;

   localparam logic [2:0] CMP_EQ = 3'd0;
   localparam logic [2:0] CMP_NE = 3'd1;
   localparam logic [2:0] CMP_GT = 3'd2;
   localparam logic [2:0] CMP_LT = 3'd3;
   localparam logic [2:0] CMP_GE = 3'd4;
   localparam logic [2:0] CMP_LE = 3'd5;

   localparam logic [1:0] ACT_NONE    = 2'd0;
   localparam logic [1:0] ACT_ADDED   = 2'd1;
   localparam logic [1:0] ACT_REMOVED = 2'd2;

   typedef struct packed {
      logic [1:0]  opcode;
      logic [15:0] address;
      logic [2:0]  kind;
      logic [7:0]  mem_data;
      logic [2:0]  entry_index;
      logic [15:0] range_end;
      logic [7:0]  cmp_value;
      logic [7:0]  cmp_mask;
      logic [2:0]  cmp_op;
   } req_type;

   typedef struct packed {
      logic       hit;
      logic [2:0] hit_index;
      logic [1:0] toggle_action;
   } rsp_type;

   typedef struct packed {
      logic [15:0] start_addr;
      logic [15:0] end_addr;
      logic [7:0]  value;
      logic [7:0]  mask;
      logic [2:0]  op;
      logic [2:0]  kind;
   } entry_type;

   typedef struct packed {
      logic      en;
      logic      clear;
      entry_type data;
   } wr_cmd_type;

endpackage

@@ rtl/dbt_mem.sv @@
module dbt_mem #(
   parameter int ENTRIES = dbt_pkg::ENTRIES_DEFAULT,
   localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [IDX_W-1:0]     rd_idx,
   output dbt_pkg::entry_type   rd_entry,
   input  logic [IDX_W-1:0]     wr_idx,
   input  dbt_pkg::wr_cmd_type  wr_cmd
);

   dbt_pkg::entry_type mem [ENTRIES];
   logic [ENTRIES-1:0] valid_ff;
   dbt_pkg::entry_type rd_data_ff;
   logic               rd_valid_ff;

   // entries never written read back as kind none
   always_ff @(posedge clock) begin
      if (wr_cmd.en && !wr_cmd.clear) begin
         mem[wr_idx] <= wr_cmd.data;
      end
      rd_data_ff <= mem[rd_idx];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (wr_cmd.en) begin
            valid_ff[wr_idx] <= !wr_cmd.clear;
         end
         rd_valid_ff <= valid_ff[rd_idx];
      end
   end

   assign rd_entry = rd_valid_ff ? rd_data_ff : '0;

endmodule

@@ rtl/dbt_seq.sv @@
module dbt_seq #(
   parameter int ENTRIES = dbt_pkg::ENTRIES_DEFAULT,
   localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  dbt_pkg::req_type     in_data,
   output logic                 out_valid,
   input  logic                 out_ready,
   output dbt_pkg::rsp_type     out_data,
   output logic [IDX_W-1:0]     rd_idx,
   input  dbt_pkg::entry_type   rd_entry,
   output logic [IDX_W-1:0]     wr_idx,
   output dbt_pkg::wr_cmd_type  wr_cmd
);

   typedef enum logic [1:0] {S_IDLE, S_START, S_SCAN, S_OUT} state_type;

   state_type          state_ff, state_in;
   dbt_pkg::req_type   req_ff, req_in;
   dbt_pkg::rsp_type   res_ff, res_in;
   logic [IDX_W-1:0]   eval_idx_ff, eval_idx_in;
   logic [IDX_W-1:0]   free_idx_ff, free_idx_in;
   logic               free_found_ff, free_found_in;
   logic               covers;
   logic               matched;
   logic               is_last;
   logic               cmp_ok;
   logic [7:0]         masked;

   function automatic logic cmp_byte(input logic [2:0] op, input logic [7:0] lhs,
                                     input logic [7:0] rhs);
      logic res;
      case (op)
         dbt_pkg::CMP_EQ: res = (lhs == rhs);
         dbt_pkg::CMP_NE: res = (lhs != rhs);
         dbt_pkg::CMP_GT: res = (lhs > rhs);
         dbt_pkg::CMP_LT: res = (lhs < rhs);
         dbt_pkg::CMP_GE: res = (lhs >= rhs);
         dbt_pkg::CMP_LE: res = (lhs <= rhs);
         default:         res = 1'b0;
      endcase
      return res;
   endfunction

   assign covers  = (req_ff.address >= rd_entry.start_addr) &&
                    (req_ff.address <= rd_entry.end_addr);
   assign matched = (rd_entry.kind == req_ff.kind) && covers;
   assign is_last = (eval_idx_ff == IDX_W'(ENTRIES - 1));
   assign masked  = req_ff.mem_data & rd_entry.mask;
   assign cmp_ok  = cmp_byte(rd_entry.op, masked, rd_entry.value);

   always_comb begin
      state_in      = state_ff;
      req_in        = req_ff;
      res_in        = res_ff;
      eval_idx_in   = eval_idx_ff;
      free_idx_in   = free_idx_ff;
      free_found_in = free_found_ff;
      rd_idx        = eval_idx_ff + 1'b1;
      wr_idx        = free_idx_ff;
      wr_cmd        = '0;
      out_valid     = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (in_valid) begin
               req_in        = in_data;
               res_in        = '0;
               free_found_in = 1'b0;
               eval_idx_in   = '0;
               state_in      = S_START;
            end
         end
         S_START: begin
            rd_idx      = '0;
            eval_idx_in = '0;
            unique case (req_ff.opcode)
               dbt_pkg::OP_CHECK: begin
                  state_in = (req_ff.kind == dbt_pkg::KIND_NONE) ? S_OUT : S_SCAN;
               end
               dbt_pkg::OP_TOGGLE: begin
                  state_in = S_SCAN;
               end
               dbt_pkg::OP_WRITE: begin
                  if (32'(req_ff.entry_index) < ENTRIES) begin
                     wr_cmd.en              = 1'b1;
                     wr_cmd.data.start_addr = req_ff.address;
                     wr_cmd.data.end_addr   = req_ff.range_end;
                     wr_cmd.data.value      = req_ff.cmp_value;
                     wr_cmd.data.mask       = req_ff.cmp_mask;
                     wr_cmd.data.op         = req_ff.cmp_op;
                     wr_cmd.data.kind       = req_ff.kind;
                     wr_idx                 = IDX_W'(req_ff.entry_index);
                  end
                  state_in = S_OUT;
               end
               dbt_pkg::OP_NOP: begin
                  state_in = S_OUT;
               end
            endcase
         end
         S_SCAN: begin
            eval_idx_in = eval_idx_ff + 1'b1;
            if (req_ff.opcode == dbt_pkg::OP_CHECK) begin
               if (matched) begin
                  res_in.hit = (req_ff.kind != dbt_pkg::KIND_WMEM) || cmp_ok;
                  res_in.hit_index = res_in.hit ? 3'(eval_idx_ff) : 3'd0;
                  state_in = S_OUT;
               end else if (is_last) begin
                  state_in = S_OUT;
               end
            end else begin
               if (rd_entry.kind == dbt_pkg::KIND_NONE && !free_found_ff) begin
                  free_found_in = 1'b1;
                  free_idx_in   = eval_idx_ff;
               end
               if (rd_entry.kind == dbt_pkg::KIND_EXEC && covers) begin
                  wr_cmd.en            = 1'b1;
                  wr_cmd.clear         = 1'b1;
                  wr_idx               = eval_idx_ff;
                  res_in.toggle_action = dbt_pkg::ACT_REMOVED;
                  state_in             = S_OUT;
               end else if (is_last) begin
                  if (free_found_in) begin
                     wr_cmd.en              = 1'b1;
                     wr_cmd.data.start_addr = req_ff.address;
                     wr_cmd.data.end_addr   = req_ff.address;
                     wr_cmd.data.kind       = dbt_pkg::KIND_EXEC;
                     wr_idx                 = free_idx_in;
                     res_in.toggle_action   = dbt_pkg::ACT_ADDED;
                  end
                  state_in = S_OUT;
               end
            end
         end
         S_OUT: begin
            out_valid = 1'b1;
            if (out_ready) begin
               state_in = S_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      res_ff      <= res_in;
      eval_idx_ff <= eval_idx_in;
      free_idx_ff <= free_idx_in;
      if (reset) begin
         state_ff      <= S_IDLE;
         free_found_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         free_found_ff <= free_found_in;
      end
   end

   assign in_ready = (state_ff == S_IDLE);
   assign out_data = res_ff;

endmodule

@@ rtl/debug_breakpoint_table_unit.sv @@
// Breakpoint and watchpoint table. One request beat is taken at a time: a
// check or toggle walks the table through its single read port, one entry per
// cycle, and a check stops at the first entry of its kind that covers the
// address. A table write, an unused opcode and a check of kind none skip the
// walk. A finished response sits in an output register, so the next request
// is taken while the previous response is still stalled. Table state is
// cleared by reset.
`include "debug_breakpoint_table_unit_assert.svh"

module debug_breakpoint_table_unit #(
   parameter int ENTRIES = dbt_pkg::ENTRIES_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  dbt_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output dbt_pkg::rsp_type  rsp_data
);

   localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

   logic                 seq_ready;
   logic                 seq_out_valid;
   logic                 seq_out_ready;
   dbt_pkg::rsp_type     seq_out_data;
   logic [IDX_W-1:0]     rd_idx;
   dbt_pkg::entry_type   rd_entry;
   logic [IDX_W-1:0]     wr_idx;
   dbt_pkg::wr_cmd_type  wr_cmd;
   logic                 rsp_valid_ff;
   dbt_pkg::rsp_type     rsp_data_ff;

   dbt_seq #(.ENTRIES(ENTRIES)) u_seq (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (seq_ready),
      .in_data   (req_data),
      .out_valid (seq_out_valid),
      .out_ready (seq_out_ready),
      .out_data  (seq_out_data),
      .rd_idx    (rd_idx),
      .rd_entry  (rd_entry),
      .wr_idx    (wr_idx),
      .wr_cmd    (wr_cmd)
   );

   dbt_mem #(.ENTRIES(ENTRIES)) u_mem (
      .clock    (clock),
      .reset    (reset),
      .rd_idx   (rd_idx),
      .rd_entry (rd_entry),
      .wr_idx   (wr_idx),
      .wr_cmd   (wr_cmd)
   );

   assign req_stall     = !seq_ready;
   assign seq_out_ready = !rsp_valid_ff || !rsp_stall;

   // response beat register
   always_ff @(posedge clock) begin
      if (seq_out_valid && seq_out_ready) begin
         rsp_data_ff <= seq_out_data;
      end
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (seq_out_valid && seq_out_ready) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `DBT_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && !req_stall, req_stall)
   `DBT_ASSERT_SAME(a_index_needs_hit, clock, reset, rsp_valid && !rsp_data.hit, rsp_data.hit_index == 3'd0)
   `DBT_ASSERT_SAME(a_hit_not_toggle, clock, reset, seq_out_valid && seq_out_data.hit, seq_out_data.toggle_action == dbt_pkg::ACT_NONE)

endmodule
